// ===== rtl/clm_pkg.sv =====
// Package with shared constants and types for the lock manager.
package clm_pkg;

    localparam int NUM_LOCKS_DEF   = 64;
    localparam int NUM_CLIENTS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int XID_W    = 32;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RETRY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOENTRY = 2'd2;

    localparam logic [KIND_W-1:0] MSG_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] MSG_REVOKE = 2'd1;
    localparam logic [KIND_W-1:0] MSG_RETRY  = 2'd2;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // One result word as it travels from the engine to the output register.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KIND_W-1:0]   message_kind;
        logic [5:0]          message_client;
        logic [XID_W-1:0]    message_xid;
        logic                waiters_overflow;
    } result_t;

endpackage

// ===== rtl/clm_outreg.sv =====
// Output register that holds one result word until it is taken.
module clm_outreg
    import clm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t data,
    output logic    busy,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_data
);

    logic    valid_reg;
    result_t data_reg;

    // Hold the word until the consumer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign busy      = valid_reg;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/clm_engine.sv =====
// Sequencer that reads, updates and writes back the lock and pair memories.
module clm_engine
    import clm_pkg::*;
#(
    parameter int NUM_LOCKS   = NUM_LOCKS_DEF,
    parameter int NUM_CLIENTS = NUM_CLIENTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             cmd,
    input  logic [5:0]       lock_in,
    input  logic [2:0]       client_in,
    input  logic [XID_W-1:0] xid_in,
    input  logic             out_free,
    output logic             idle,
    output logic             done,
    output result_t          result
);

    localparam int LW  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int CW  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PW  = LW + CW;
    localparam int NP  = 1 << PW;
    localparam int SW  = LW + QW;
    localparam int NS  = 1 << SW;
    localparam int PEW = XID_W + 3;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_DEC    = 4'd3;
    localparam logic [3:0] S_HRD    = 4'd4;
    localparam logic [3:0] S_HWAIT  = 4'd5;
    localparam logic [3:0] S_SRCH   = 4'd6;
    localparam logic [3:0] S_SWAIT  = 4'd7;
    localparam logic [3:0] S_SHRD   = 4'd8;
    localparam logic [3:0] S_SHWAIT = 4'd9;
    localparam logic [3:0] S_SHWR   = 4'd10;
    localparam logic [3:0] S_PRD    = 4'd11;
    localparam logic [3:0] S_PWAIT  = 4'd12;
    localparam logic [3:0] S_WB     = 4'd13;

    // Lock entry: known, held, holder, head, count.
    localparam int LEW = 2 + CW + QW + NW;

    logic [LEW-1:0] lock_mem [NUM_LOCKS];
    logic [PEW-1:0] pair_mem [NP];
    logic [CW-1:0]  slot_mem [NS];

    logic [3:0]       state_reg, state_next;
    logic [PW:0]      clr_reg;
    logic             cmd_reg;
    logic [LW-1:0]    lk_reg;
    logic [CW-1:0]    cl_reg;
    logic [XID_W-1:0] xid_reg;

    logic [LEW-1:0] lrd_reg;
    logic [PEW-1:0] prd_reg;
    logic [CW-1:0]  srd_reg;

    // Working copy of the lock entry.
    logic             known_reg, held_reg;
    logic [CW-1:0]    holder_reg;
    logic [QW-1:0]    head_reg;
    logic [NW-1:0]    count_reg;
    // Working copy of the pair entry.
    logic [XID_W-1:0] pxid_reg;
    logic             pseen_reg, pans_reg, pdone_reg;

    logic [NW-1:0]    pos_reg;
    logic             found_reg;
    logic             drop_reg;
    logic             msg_reg;
    result_t          res_reg;

    logic             l_ren, p_ren, s_ren;
    logic [LW-1:0]    l_addr;
    logic [PW-1:0]    p_addr;
    logic [SW-1:0]    s_addr;
    logic             l_wen, p_wen, s_wen;
    logic [LEW-1:0]   l_wdata;
    logic [PEW-1:0]   p_wdata;
    logic [CW-1:0]    s_wdata;

    // Fields of the entries as they come out of memory.
    logic             d_known, d_held;
    logic [CW-1:0]    d_holder;
    logic [NW-1:0]    d_count;
    logic [XID_W-1:0] d_pxid;
    logic             d_pseen, d_pans, d_pdone;

    // Values decided for the current request.
    logic             fresh;
    logic             dec_known, dec_held, dec_pseen, dec_pans, dec_pdone;
    logic [CW-1:0]    dec_holder;
    logic [XID_W-1:0] dec_pxid;
    logic             dec_drop, dec_msg;
    logic [3:0]       dec_path;
    result_t          dec_res, hw_res, res_out;
    logic [NW-1:0]    cnt_m1;
    logic [QW-1:0]    head_inc;

    // Slot address of queue position p, wrapped around the ring of the lock.
    function automatic logic [SW-1:0] slot_addr(input logic [LW-1:0] lk,
                                                input logic [QW-1:0] h,
                                                input logic [NW-1:0] p);
        logic [NW:0] s;
        s = {1'b0, p} + (NW+1)'(h);
        if (s >= (NW+1)'(QUEUE_DEPTH))
        begin
            s = s - (NW+1)'(QUEUE_DEPTH);
        end
        return {lk, s[QW-1:0]};
    endfunction

    // Lock number modulo NUM_LOCKS by conditional subtraction.
    function automatic logic [LW-1:0] lock_mod(input logic [5:0] v);
        logic [31:0] r;
        r = 32'(v);
        for (int k = 5; k >= 0; k--)
        begin
            if (r >= (32'(NUM_LOCKS) << k))
            begin
                r = r - (32'(NUM_LOCKS) << k);
            end
        end
        return LW'(r);
    endfunction

    // Client number modulo NUM_CLIENTS by conditional subtraction.
    function automatic logic [CW-1:0] client_mod(input logic [2:0] v);
        logic [31:0] r;
        r = 32'(v);
        for (int k = 2; k >= 0; k--)
        begin
            if (r >= (32'(NUM_CLIENTS) << k))
            begin
                r = r - (32'(NUM_CLIENTS) << k);
            end
        end
        return CW'(r);
    endfunction

    // Memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (l_wen)
        begin
            lock_mem[l_addr] <= l_wdata;
        end
        if (l_ren)
        begin
            lrd_reg <= lock_mem[l_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_wen)
        begin
            pair_mem[p_addr] <= p_wdata;
        end
        if (p_ren)
        begin
            prd_reg <= pair_mem[p_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_wen)
        begin
            slot_mem[s_addr] <= s_wdata;
        end
        if (s_ren)
        begin
            srd_reg <= slot_mem[s_addr];
        end
    end

    assign d_known  = lrd_reg[LEW-1];
    assign d_held   = lrd_reg[LEW-2];
    assign d_holder = lrd_reg[LEW-3 -: CW];
    assign d_count  = lrd_reg[NW-1:0];
    assign d_pxid   = prd_reg[PEW-1:3];
    assign d_pseen  = prd_reg[2];
    assign d_pans   = prd_reg[1];
    assign d_pdone  = prd_reg[0];

    assign cnt_m1   = count_reg - NW'(1);
    assign head_inc = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QW'(1);

    // Decision on the freshly read entries: new entry values, result and path.
    always_comb
    begin
        dec_known  = d_known;
        dec_held   = d_held;
        dec_holder = d_holder;
        dec_pxid   = d_pxid;
        dec_pseen  = d_pseen;
        dec_pans   = d_pans;
        dec_pdone  = d_pdone;
        dec_res    = '0;
        dec_drop   = 1'b0;
        dec_msg    = 1'b0;
        dec_path   = S_WB;
        fresh      = !d_pseen || (xid_reg > d_pxid);
        if (cmd_reg == CMD_ACQUIRE)
        begin
            if (!d_known)
            begin
                dec_known  = 1'b1;
                dec_held   = 1'b1;
                dec_holder = cl_reg;
                dec_pxid   = xid_reg;
                dec_pseen  = 1'b1;
            end
            else if (fresh)
            begin
                dec_pxid  = xid_reg;
                dec_pseen = 1'b1;
                dec_pdone = 1'b0;
                if (!d_held)
                begin
                    dec_held   = 1'b1;
                    dec_holder = cl_reg;
                    dec_pans   = 1'b0;
                    dec_msg    = 1'b1;
                    if (d_count != '0)
                    begin
                        dec_path = S_SRCH;
                    end
                end
                else
                begin
                    dec_pans       = 1'b1;
                    dec_res.status = ST_RETRY;
                    if (d_count >= NW'(QUEUE_DEPTH))
                    begin
                        dec_res.waiters_overflow = 1'b1;
                    end
                    else
                    begin
                        dec_drop = 1'b1;
                    end
                    if (d_count == '0)
                    begin
                        dec_path = S_HRD;
                    end
                end
            end
            else if (xid_reg == d_pxid)
            begin
                dec_res.status = d_pans ? ST_RETRY : ST_OK;
            end
        end
        else
        begin
            if (!d_known || !d_held || d_holder != cl_reg || !d_pseen)
            begin
                dec_res.status = ST_NOENTRY;
            end
            else if (d_pxid == xid_reg && !d_pdone)
            begin
                dec_held  = 1'b0;
                dec_pdone = 1'b1;
                if (d_count != '0)
                begin
                    dec_path = S_SHRD;
                end
            end
        end
    end

    // Address, write and next-state selection.
    always_comb
    begin
        state_next = state_reg;
        l_ren = 1'b0; p_ren = 1'b0; s_ren = 1'b0;
        l_wen = 1'b0; p_wen = 1'b0; s_wen = 1'b0;
        l_addr = lk_reg;
        p_addr = {cl_reg, lk_reg};
        s_addr = slot_addr(lk_reg, head_reg, pos_reg);
        l_wdata = {known_reg, held_reg, holder_reg, head_reg, count_reg};
        p_wdata = {pxid_reg, pseen_reg, pans_reg, pdone_reg};
        s_wdata = cl_reg;
        case (state_reg)
            S_CLEAR:
            begin
                p_wen = 1'b1;
                p_addr = clr_reg[PW-1:0];
                p_wdata = '0;
                l_wen = (clr_reg < (PW+1)'(NUM_LOCKS));
                l_addr = clr_reg[LW-1:0];
                l_wdata = '0;
                if (clr_reg == (PW+1)'(NP - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                l_ren = 1'b1;
                p_ren = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                // Entries were just latched; decide the path.
                state_next = dec_path;
            end
            S_HRD:
            begin
                p_ren = 1'b1;
                p_addr = {holder_reg, lk_reg};
                state_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                state_next = S_WB;
            end
            S_SRCH:
            begin
                // One slot read per pass, compared in S_SWAIT.
                s_ren = 1'b1;
                state_next = S_SWAIT;
            end
            S_SWAIT:
            begin
                if (found_reg)
                begin
                    // Shift the next waiter down one place; the count is already one lower.
                    if (pos_reg + NW'(1) < count_reg + NW'(1))
                    begin
                        s_ren = 1'b1;
                        s_addr = slot_addr(lk_reg, head_reg, pos_reg + NW'(1));
                        state_next = S_SHWAIT;
                    end
                    else
                    begin
                        state_next = S_WB;
                    end
                end
                else if (srd_reg == cl_reg)
                begin
                    if (pos_reg + NW'(1) < count_reg)
                    begin
                        s_ren = 1'b1;
                        s_addr = slot_addr(lk_reg, head_reg, pos_reg + NW'(1));
                        state_next = S_SHWAIT;
                    end
                    else
                    begin
                        state_next = S_WB;
                    end
                end
                else if (pos_reg + NW'(1) < count_reg)
                begin
                    state_next = S_SRCH;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_SHWAIT:
            begin
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                s_wen = 1'b1;
                s_wdata = srd_reg;
                state_next = S_SWAIT;
            end
            S_SHRD:
            begin
                s_ren = 1'b1;
                s_addr = slot_addr(lk_reg, head_reg, '0);
                state_next = S_PRD;
            end
            S_PRD:
            begin
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                p_ren = 1'b1;
                p_addr = {srd_reg, lk_reg};
                state_next = S_HWAIT;
            end
            S_WB:
            begin
                // Write back and finish only once the output register can take the word.
                l_wen = out_free;
                p_wen = out_free;
                s_wen = drop_reg && out_free;
                s_addr = slot_addr(lk_reg, head_reg, count_reg);
                l_wdata = {known_reg, held_reg, holder_reg, head_reg,
                           drop_reg ? count_reg + NW'(1) : count_reg};
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg <= cmd;
                lk_reg  <= lock_mod(lock_in);
                cl_reg  <= client_mod(client_in);
                xid_reg <= xid_in;
                pos_reg <= '0;
                found_reg <= 1'b0;
                drop_reg <= 1'b0;
                msg_reg <= 1'b0;
            end
            S_DEC:
            begin
                known_reg  <= dec_known;
                held_reg   <= dec_held;
                holder_reg <= dec_holder;
                head_reg   <= lrd_reg[NW +: QW];
                count_reg  <= d_count;
                pxid_reg   <= dec_pxid;
                pseen_reg  <= dec_pseen;
                pans_reg   <= dec_pans;
                pdone_reg  <= dec_pdone;
                res_reg    <= dec_res;
                drop_reg   <= dec_drop;
                msg_reg    <= dec_msg;
            end
            S_HWAIT:
            begin
                res_reg <= hw_res;
                if (cmd_reg == CMD_RELEASE)
                begin
                    head_reg  <= head_inc;
                    count_reg <= cnt_m1;
                end
            end
            S_SWAIT:
            begin
                if (found_reg || srd_reg == cl_reg)
                begin
                    if (!found_reg)
                    begin
                        count_reg <= cnt_m1;
                    end
                    found_reg <= 1'b1;
                end
                else
                begin
                    pos_reg <= pos_reg + NW'(1);
                end
            end
            S_SHWR:
            begin
                pos_reg <= pos_reg + NW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Holder revoke or waiter retry uses the xid just read; a holder that is
    // the requester itself already carries the new xid.
    always_comb
    begin
        hw_res = res_reg;
        if (cmd_reg == CMD_ACQUIRE)
        begin
            hw_res.message_kind   = MSG_REVOKE;
            hw_res.message_client = 6'(holder_reg);
            hw_res.message_xid    = (holder_reg == cl_reg) ? xid_reg : prd_reg[PEW-1:3];
        end
        else
        begin
            hw_res.message_kind   = MSG_RETRY;
            hw_res.message_client = 6'(srd_reg);
            hw_res.message_xid    = prd_reg[PEW-1:3];
        end
    end

    // Revoke to the new holder is decided once the queue is final.
    always_comb
    begin
        res_out = res_reg;
        if (msg_reg && count_reg != '0)
        begin
            res_out.message_kind   = MSG_REVOKE;
            res_out.message_client = 6'(cl_reg);
            res_out.message_xid    = xid_reg;
        end
    end

    assign idle   = (state_reg == S_IDLE);
    assign done   = (state_reg == S_WB);
    assign result = res_out;

endmodule

// ===== rtl/cached_lock_manager.sv =====
// Top level of the cached lock manager.
//  channel | signals                                        | dir
//  in      | in_valid/in_ready, command, lock_index,        | to block
//          | client_index, request_xid                      |
//  out     | out_valid/out_ready, status, message_kind,     | from block
//          | message_client, message_xid, waiters_overflow  |
// After acceptance an item is read, decided and written back before the next
// word can be accepted. Revoking the holder adds a read of its pair entry,
// handing a released lock to a waiter adds reads of the head slot and of that
// waiter's pair entry, and taking a free lock searches and compacts the waiter
// queue one slot at a time. After reset a clearing pass over the pair memory
// runs; no word is accepted until it ends.
// A result waits in the output register; the engine holds in writeback until
// that register is free.
module cached_lock_manager
    import clm_pkg::*;
#(
    parameter int NUM_LOCKS   = NUM_LOCKS_DEF,
    parameter int NUM_CLIENTS = NUM_CLIENTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             command,
    input  logic [5:0]       lock_index,
    input  logic [2:0]       client_index,
    input  logic [XID_W-1:0] request_xid,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [1:0]       message_kind,
    output logic [2:0]       message_client,
    output logic [XID_W-1:0] message_xid,
    output logic             waiters_overflow
);

    logic    eng_idle, eng_done, obusy;
    result_t eng_res, o_data;
    logic    hold_ok;

    clm_engine #(
        .NUM_LOCKS(NUM_LOCKS),
        .NUM_CLIENTS(NUM_CLIENTS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .start(in_valid && in_ready),
        .cmd(command),
        .lock_in(lock_index),
        .client_in(client_index),
        .xid_in(request_xid),
        .out_free(hold_ok),
        .idle(eng_idle),
        .done(eng_done),
        .result(eng_res)
    );

    // The engine finishes only into a free output register.
    assign hold_ok  = !obusy || out_ready;
    assign in_ready = eng_idle;

    clm_outreg u_out (
        .clk(clk),
        .rst_n(rst_n),
        .load(eng_done && hold_ok),
        .data(eng_res),
        .busy(obusy),
        .out_ready(out_ready),
        .out_valid(out_valid),
        .out_data(o_data)
    );

    assign status           = o_data.status;
    assign message_kind     = o_data.message_kind;
    assign message_client   = o_data.message_client[2:0];
    assign message_xid      = o_data.message_xid;
    assign waiters_overflow = o_data.waiters_overflow;

endmodule

// ===== rtl/clm_checker.sv =====
// Port checker for the lock manager, bound to the top level.
module clm_checker
    import clm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [1:0]  message_kind,
    input logic        waiters_overflow
);

    // Codes never exceed their defined ranges.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_NOENTRY && message_kind <= MSG_RETRY))
        else $error("bad code");

    // Overflow only comes with a retry status.
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && waiters_overflow) |-> status == ST_RETRY) else $error("bad overflow");

    // A result cannot appear in the cycle right after an accept.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid) else $error("too fast");

    // A waiting result stays until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result lost");

endmodule

bind cached_lock_manager clm_checker u_clm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .message_kind(message_kind),
    .waiters_overflow(waiters_overflow)
);
